// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int MODE_W = 3;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int REL_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

    localparam logic [REL_W-1:0] REL_LESS = 2'd0;
    localparam logic [REL_W-1:0] REL_EQUAL = 2'd1;
    localparam logic [REL_W-1:0] REL_GREATER = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DIV_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_DEN = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_A,
        OP_RED_B,
        OP_CROSS,
        OP_COMBINE,
        OP_RED_R,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } stat_t;

endpackage

// ----- rtl/rau_if.sv -----
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// valid/ready channels of the rational arithmetic unit
// ----------------------------------------------------------------------------
interface rau_in_if #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [rau_pkg::MODE_W-1:0]      mode;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rau_pkg::NUM_W-1:0]  res_num;
    logic [rau_pkg::DEN_W-1:0]         res_den;
    logic [rau_pkg::REL_W-1:0]         relation;
    logic [rau_pkg::STAT_W-1:0]        status;

    modport source (output valid, res_num, res_den, relation, status, input ready);
    modport sink (input valid, res_num, res_den, relation, status, output ready);
endinterface

// ----- rtl/rau_reduce.sv -----
// ----------------------------------------------------------------------------
// rau_reduce
// reduces a magnitude pair by its gcd: euclid steps by restoring division
// ----------------------------------------------------------------------------
module rau_reduce #(
    parameter int W = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] n_in,
    input  logic [W-1:0] d_in,
    output logic         done,
    output logic [W-1:0] n_out,
    output logic [W-1:0] d_out
);

    localparam int CW = $clog2(W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIVN = 3'd2;
    localparam logic [2:0] S_DIVD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [W-1:0]  n_reg, n_next, d_reg, d_next;
    logic [W-1:0]  q_reg, q_next, r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;
    logic [W-1:0]  divisor, dividend;
    logic [W-1:0]  rem;

    // one quotient bit per cycle, shared by all three divisions
    always_comb
    begin
        divisor = (state_reg == S_GCD) ? y_reg : x_reg;
        dividend = q_reg;
        trial = {r_reg, dividend[W-1]} - {1'b0, divisor};
        if (!trial[W])
            rem = trial[W-1:0];
        else
            rem = {r_reg[W-2:0], dividend[W-1]};
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        n_next = n_reg;
        d_next = d_reg;
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = n_in;
                    d_next = d_in;
                    x_next = n_in;
                    y_next = d_in;
                    q_next = n_in;
                    r_next = '0;
                    cnt_next = CW'(W);
                    if (d_in == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_GCD;
                end
            end
            S_GCD, S_DIVN, S_DIVD:
            begin
                r_next = rem;
                q_next = {q_reg[W-2:0], ~trial[W]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    cnt_next = CW'(W);
                    q_next = '0;
                    r_next = '0;
                    if (state_reg == S_GCD)
                    begin
                        if (rem == '0)
                        begin
                            // gcd is y_reg, held in x for the divisions
                            x_next = y_reg;
                            q_next = n_reg;
                            state_next = S_DIVN;
                        end
                        else
                        begin
                            x_next = y_reg;
                            y_next = rem;
                            q_next = y_reg;
                        end
                    end
                    else if (state_reg == S_DIVN)
                    begin
                        n_next = {q_reg[W-2:0], ~trial[W]};
                        q_next = d_reg;
                        state_next = S_DIVD;
                    end
                    else
                    begin
                        d_next = {q_reg[W-2:0], ~trial[W]};
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        n_reg <= n_next;
        d_reg <= d_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = (state_reg == S_DONE);
    assign n_out = n_reg;
    assign d_out = d_reg;

endmodule

// ----- rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, cross products, combine and output formatting
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::cmd_t     cmd,
    output rau_pkg::stat_t    stat,
    rau_in_if.sink            in_ch,
    rau_out_if.source         out_ch
);

    localparam int OW = OPERAND_WIDTH;
    localparam int PW = 2 * OW;
    localparam int RW = PW + 2;

    logic [rau_pkg::MODE_W-1:0] mode_reg;
    logic an_s_reg, bn_s_reg, rn_s_reg;
    logic [OW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [PW-1:0] p1_reg, p2_reg, pd_reg;
    logic [RW-1:0] rn_reg, rd_reg;
    logic p1_s_reg, p2_s_reg;
    logic zden_reg;
    logic ov_valid_reg;
    logic signed [rau_pkg::NUM_W-1:0] ov_num_reg;
    logic [rau_pkg::DEN_W-1:0] ov_den_reg;
    logic [rau_pkg::REL_W-1:0] ov_rel_reg;
    logic [rau_pkg::STAT_W-1:0] ov_stat_reg;

    logic red_start, red_done;
    logic [RW-1:0] red_n_in, red_d_in, red_n, red_d;

    logic [OW-1:0] an_m, ad_m, bn_m, bd_m;
    logic [PW:0] sum_mag;
    logic sum_s;
    logic p2_s_eff;

    always_comb
    begin
        an_m = in_ch.a_num[OW-1] ? OW'(-in_ch.a_num) : OW'(in_ch.a_num);
        ad_m = in_ch.a_den[OW-1] ? OW'(-in_ch.a_den) : OW'(in_ch.a_den);
        bn_m = in_ch.b_num[OW-1] ? OW'(-in_ch.b_num) : OW'(in_ch.b_num);
        bd_m = in_ch.b_den[OW-1] ? OW'(-in_ch.b_den) : OW'(in_ch.b_den);
    end

    always_comb
    begin
        red_start = 1'b0;
        red_n_in = '0;
        red_d_in = '0;
        case (cmd.op)
            rau_pkg::OP_RED_A:
            begin
                red_start = cmd.start;
                red_n_in = RW'(an_reg);
                red_d_in = RW'(ad_reg);
            end
            rau_pkg::OP_RED_B:
            begin
                red_start = cmd.start;
                red_n_in = RW'(bn_reg);
                red_d_in = RW'(bd_reg);
            end
            rau_pkg::OP_RED_R:
            begin
                red_start = cmd.start;
                red_n_in = rn_reg;
                red_d_in = rd_reg;
            end
            default:
            begin
                red_start = 1'b0;
            end
        endcase
    end

    rau_reduce #(.W(RW)) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .n_in  (red_n_in),
        .d_in  (red_d_in),
        .done  (red_done),
        .n_out (red_n),
        .d_out (red_d)
    );

    always_comb
    begin
        p2_s_eff = p2_s_reg ^ (mode_reg == rau_pkg::MODE_SUB);
        if (p2_reg == '0)
            p2_s_eff = 1'b0;
        if (p1_s_reg == p2_s_eff)
        begin
            sum_mag = {1'b0, p1_reg} + {1'b0, p2_reg};
            sum_s = p1_s_reg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_mag = {1'b0, p1_reg - p2_reg};
            sum_s = p1_s_reg;
        end
        else
        begin
            sum_mag = {1'b0, p2_reg - p1_reg};
            sum_s = p2_s_eff;
        end
        if (sum_mag == '0)
            sum_s = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rau_pkg::OP_LOAD:
            begin
                mode_reg <= in_ch.mode;
                an_reg <= an_m;
                ad_reg <= ad_m;
                bn_reg <= bn_m;
                bd_reg <= bd_m;
                an_s_reg <= (in_ch.a_num[OW-1] ^ in_ch.a_den[OW-1]) && (an_m != '0);
                bn_s_reg <= (in_ch.b_num[OW-1] ^ in_ch.b_den[OW-1]) && (bn_m != '0);
                zden_reg <= (ad_m == '0) || (bd_m == '0);
            end
            rau_pkg::OP_RED_A:
            begin
                if (red_done)
                begin
                    an_reg <= OW'(red_n);
                    ad_reg <= OW'(red_d);
                end
            end
            rau_pkg::OP_RED_B:
            begin
                if (red_done)
                begin
                    bn_reg <= OW'(red_n);
                    bd_reg <= OW'(red_d);
                end
            end
            rau_pkg::OP_CROSS:
            begin
                case (mode_reg)
                    rau_pkg::MODE_MUL:
                    begin
                        p1_reg <= an_reg * bn_reg;
                        p1_s_reg <= an_s_reg ^ bn_s_reg;
                        pd_reg <= ad_reg * bd_reg;
                    end
                    rau_pkg::MODE_DIV:
                    begin
                        p1_reg <= an_reg * bd_reg;
                        p1_s_reg <= an_s_reg ^ bn_s_reg;
                        pd_reg <= ad_reg * bn_reg;
                    end
                    default:
                    begin
                        p1_reg <= an_reg * bd_reg;
                        p1_s_reg <= an_s_reg;
                        pd_reg <= ad_reg * bd_reg;
                    end
                endcase
                p2_reg <= bn_reg * ad_reg;
                p2_s_reg <= bn_s_reg;
            end
            rau_pkg::OP_COMBINE:
            begin
                rd_reg <= RW'(pd_reg);
                if (mode_reg == rau_pkg::MODE_ADD || mode_reg == rau_pkg::MODE_SUB)
                begin
                    rn_reg <= RW'(sum_mag);
                    rn_s_reg <= sum_s;
                end
                else
                begin
                    rn_reg <= RW'(p1_reg);
                    rn_s_reg <= p1_s_reg && (p1_reg != '0);
                end
            end
            rau_pkg::OP_RED_R:
            begin
                if (red_done)
                begin
                    rn_reg <= red_n;
                    rd_reg <= red_d;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register and formatting
    logic signed [rau_pkg::NUM_W-1:0] fmt_num;
    logic [rau_pkg::DEN_W-1:0] fmt_den;
    logic [rau_pkg::REL_W-1:0] fmt_rel;
    logic [rau_pkg::STAT_W-1:0] fmt_stat;
    logic p2_s_cmp;

    always_comb
    begin
        fmt_num = '0;
        fmt_den = '0;
        fmt_rel = rau_pkg::REL_LESS;
        fmt_stat = rau_pkg::STAT_OK;
        p2_s_cmp = p2_s_reg && (p2_reg != '0);
        if (zden_reg)
            fmt_stat = rau_pkg::STAT_ZERO_DEN;
        else if (mode_reg == rau_pkg::MODE_CMP)
        begin
            if ((p1_s_reg && p1_reg != '0) != p2_s_cmp)
                fmt_rel = p2_s_cmp ? rau_pkg::REL_GREATER : rau_pkg::REL_LESS;
            else if (p1_reg == p2_reg)
                fmt_rel = rau_pkg::REL_EQUAL;
            else if (p2_s_cmp)
                fmt_rel = (p1_reg > p2_reg) ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER;
            else
                fmt_rel = (p1_reg < p2_reg) ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER;
        end
        else if (mode_reg > rau_pkg::MODE_CMP)
            fmt_stat = rau_pkg::STAT_OK;
        else if (mode_reg == rau_pkg::MODE_DIV && bn_reg == '0)
            fmt_stat = rau_pkg::STAT_DIV_ZERO;
        else
        begin
            if (rn_s_reg)
            begin
                if (rn_reg > RW'(64'h8000_0000))
                    fmt_num = 32'sh8000_0000;
                else
                    fmt_num = rau_pkg::NUM_W'(-rn_reg);
            end
            else if (rn_reg > RW'(64'h7FFF_FFFF))
                fmt_num = 32'sh7FFF_FFFF;
            else
                fmt_num = rau_pkg::NUM_W'(rn_reg);
            if (rd_reg > RW'(64'h7FFF_FFFF))
                fmt_den = 31'h7FFF_FFFF;
            else
                fmt_den = rau_pkg::DEN_W'(rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_valid_reg <= 1'b0;
        else if (cmd.op == rau_pkg::OP_FINISH)
            ov_valid_reg <= 1'b1;
        else if (out_ch.ready)
            ov_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == rau_pkg::OP_FINISH)
        begin
            ov_num_reg <= fmt_num;
            ov_den_reg <= fmt_den;
            ov_rel_reg <= fmt_rel;
            ov_stat_reg <= fmt_stat;
        end
    end

    assign in_ch.ready = (cmd.op == rau_pkg::OP_LOAD);
    assign out_ch.valid = ov_valid_reg;
    assign out_ch.res_num = ov_num_reg;
    assign out_ch.res_den = ov_den_reg;
    assign out_ch.relation = ov_rel_reg;
    assign out_ch.status = ov_stat_reg;
    assign stat.done = red_done;
    assign stat.busy = ov_valid_reg;

endmodule

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: load, reduce operands, cross products, combine, reduce, finish
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rau_pkg::stat_t stat,
    output rau_pkg::cmd_t  cmd
);

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_RED_A = 3'd1;
    localparam logic [2:0] C_RED_B = 3'd2;
    localparam logic [2:0] C_CROSS = 3'd3;
    localparam logic [2:0] C_COMB  = 3'd4;
    localparam logic [2:0] C_RED_R = 3'd5;
    localparam logic [2:0] C_FIN   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       first_reg, first_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        cmd.start = first_reg;
        cmd.op = rau_pkg::OP_NONE;
        case (state_reg)
            C_IDLE:
            begin
                // output register must be free before a new request enters
                if (!stat.busy)
                begin
                    cmd.op = rau_pkg::OP_LOAD;
                    if (in_valid)
                    begin
                        state_next = C_RED_A;
                        first_next = 1'b1;
                    end
                end
            end
            C_RED_A:
            begin
                cmd.op = rau_pkg::OP_RED_A;
                if (stat.done)
                begin
                    state_next = C_RED_B;
                    first_next = 1'b1;
                end
            end
            C_RED_B:
            begin
                cmd.op = rau_pkg::OP_RED_B;
                if (stat.done)
                    state_next = C_CROSS;
            end
            C_CROSS:
            begin
                cmd.op = rau_pkg::OP_CROSS;
                state_next = C_COMB;
            end
            C_COMB:
            begin
                cmd.op = rau_pkg::OP_COMBINE;
                state_next = C_RED_R;
                first_next = 1'b1;
            end
            C_RED_R:
            begin
                cmd.op = rau_pkg::OP_RED_R;
                if (stat.done)
                    state_next = C_FIN;
            end
            C_FIN:
            begin
                cmd.op = rau_pkg::OP_FINISH;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// rational add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// duration: grows with the euclid steps summed over the three gcd reductions,
//   shorter when an operand denominator is zero
// throughput: one request at a time, next accepted in the cycle after the result is taken
// reset: asynchronous active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);

    rau_pkg::cmd_t  cmd;
    rau_pkg::stat_t stat;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
